@@ rtl/mit_pkg.sv @@
`timescale 1ns / 1ps

package mit_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_MERGED   = 3'd0;
  localparam status_t ST_INSERTED = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_IGNORED  = 3'd3;
  localparam status_t ST_QUERY    = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Commands from the controller to the datapath. At most one is set per cycle.
  typedef struct packed {
    logic    load;
    logic    walk_start;
    logic    walk_step;
    logic    merge_place;
    logic    compact_step;
    logic    expand_start;
    logic    expand_step;
    logic    place;
    logic    q_issue;
    logic    q_eval;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic walk_stop;
    logic found;
    logic tail;
    logic pos_lt_cnt;
    logic more_copy;
    logic expand_more;
    logic q_more;
    logic q_match;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/mit_req_if.sv @@
`timescale 1ns / 1ps

interface mit_req_if #(
  parameter int PAGE_BITS = 40
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [PAGE_BITS-1:0] range_start;
  logic [PAGE_BITS-1:0] range_end;
  logic [PAGE_BITS-1:0] query_page;

  modport source (
    output valid, mode, range_start, range_end, query_page,
    input  ready
  );

  modport sink (
    input  valid, mode, range_start, range_end, query_page,
    output ready
  );
endinterface

@@ rtl/mit_rsp_if.sv @@
`timescale 1ns / 1ps

interface mit_rsp_if #(
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  mit_pkg::status_t      status;
  logic [COUNT_BITS-1:0] entry_count;

  modport source (
    output valid, hit, status, entry_count,
    input  ready
  );

  modport sink (
    input  valid, hit, status, entry_count,
    output ready
  );
endinterface

@@ rtl/mit_dp.sv @@
`timescale 1ns / 1ps

module mit_dp #(
  parameter int  MAX_RANGES = 64,
  parameter int  PAGE_BITS  = 40,
  localparam int IW = $clog2(MAX_RANGES),
  localparam int CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mit_pkg::dp_cmd_t     cmd,
  output mit_pkg::dp_sts_t     sts,
  input  logic [PAGE_BITS-1:0] in_range_start,
  input  logic [PAGE_BITS-1:0] in_range_end,
  input  logic [PAGE_BITS-1:0] in_query_page,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output mit_pkg::status_t     out_status,
  output logic [CW-1:0]        out_entry_count
);

  localparam int DW = 2 * PAGE_BITS;

  // Each entry holds {low bound, high bound}.
  logic [DW-1:0] mem [MAX_RANGES];
  logic [DW-1:0] rd_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic [PAGE_BITS-1:0] s_r, e_r, page_r;
  logic [CW-1:0]        count_r, lim_r, k_r, src_r, dst_r, l_r, rr_r;
  logic [IW-1:0]        merged_r, m_r;
  logic                 found_r, hit_r;
  logic                 out_valid_r, out_hit_r;
  mit_pkg::status_t     out_status_r;
  logic [CW-1:0]        out_count_r;

  logic [PAGE_BITS-1:0] rd_lo, rd_hi, new_s, new_e;
  logic [PAGE_BITS:0]   hi_inc, e_inc;
  logic                 cont, touch, page_lt, page_gt;
  logic [CW-1:0]        cnt_dec, k_dec1, k_dec2, merged_inc, src_inc, src_dec;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        m_w;

  assign rd_lo   = rd_data_r[DW-1:PAGE_BITS];
  assign rd_hi   = rd_data_r[PAGE_BITS-1:0];
  assign hi_inc  = {1'b0, rd_hi} + (PAGE_BITS + 1)'(1);
  assign e_inc   = {1'b0, e_r} + (PAGE_BITS + 1)'(1);
  assign cont    = {1'b0, s_r} <= hi_inc;
  assign touch   = e_inc >= {1'b0, rd_lo};
  assign new_s   = (rd_lo < s_r) ? rd_lo : s_r;
  assign new_e   = (rd_hi > e_r) ? rd_hi : e_r;
  assign page_lt = page_r < rd_lo;
  assign page_gt = page_r > rd_hi;

  assign cnt_dec    = count_r - CW'(1);
  assign k_dec1     = k_r - CW'(1);
  assign k_dec2     = k_r - CW'(2);
  assign merged_inc = CW'(merged_r) + CW'(1);
  assign src_inc    = src_r + CW'(1);
  assign src_dec    = src_r - CW'(1);
  assign mid_sum    = {1'b0, l_r} + {1'b0, rr_r} - (CW + 1)'(1);
  assign m_w        = mid_sum[CW:1];

  always_comb begin
    sts.cnt_zero    = (count_r == '0);
    sts.cnt_full    = (count_r == CW'(MAX_RANGES));
    sts.walk_stop   = !cont || (k_r == CW'(1));
    sts.found       = found_r;
    sts.tail        = (merged_inc < count_r);
    sts.pos_lt_cnt  = (k_r < count_r);
    sts.more_copy   = (src_r < lim_r);
    sts.expand_more = (src_r > k_r);
    sts.q_more      = (l_r < rr_r);
    sts.q_match     = !page_lt && !page_gt;
    sts.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {s_r, e_r};
    if (cmd.walk_start && !sts.cnt_zero) begin
      rd_en   = 1'b1;
      rd_addr = cnt_dec[IW-1:0];
    end
    if (cmd.walk_step && cont && (k_r != CW'(1))) begin
      rd_en   = 1'b1;
      rd_addr = k_dec2[IW-1:0];
    end
    if (cmd.merge_place) begin
      wr_en   = 1'b1;
      wr_addr = k_r[IW-1:0];
      if (sts.tail) begin
        rd_en   = 1'b1;
        rd_addr = merged_inc[IW-1:0];
      end
    end
    if (cmd.compact_step) begin
      wr_en   = 1'b1;
      wr_addr = dst_r[IW-1:0];
      wr_data = rd_data_r;
      if (sts.more_copy) begin
        rd_en   = 1'b1;
        rd_addr = src_r[IW-1:0];
      end
    end
    if (cmd.expand_start) begin
      rd_en   = 1'b1;
      rd_addr = cnt_dec[IW-1:0];
    end
    if (cmd.expand_step) begin
      wr_en   = 1'b1;
      wr_addr = src_inc[IW-1:0];
      wr_data = rd_data_r;
      if (sts.expand_more) begin
        rd_en   = 1'b1;
        rd_addr = src_dec[IW-1:0];
      end
    end
    if (cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = k_r[IW-1:0];
    end
    if (cmd.q_issue) begin
      rd_en   = 1'b1;
      rd_addr = m_w[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // A reversed range is stored with its bounds swapped.
      if (in_range_start > in_range_end) begin
        s_r <= in_range_end;
        e_r <= in_range_start;
      end else begin
        s_r <= in_range_start;
        e_r <= in_range_end;
      end
      page_r <= in_query_page;
      hit_r  <= 1'b0;
      l_r    <= '0;
      rr_r   <= count_r;
    end
    if (cmd.walk_start) begin
      k_r      <= count_r;
      found_r  <= 1'b0;
      merged_r <= '0;
    end
    if (cmd.walk_step && cont) begin
      k_r <= k_dec1;
      if (touch) begin
        s_r <= new_s;
        e_r <= new_e;
        if (!found_r) begin
          found_r  <= 1'b1;
          merged_r <= k_dec1[IW-1:0];
        end
      end
    end
    if (cmd.merge_place) begin
      src_r <= merged_inc + CW'(1);
      dst_r <= k_r + CW'(1);
      lim_r <= count_r;
    end
    if (cmd.compact_step) begin
      dst_r <= dst_r + CW'(1);
      if (sts.more_copy) begin
        src_r <= src_inc;
      end
    end
    if (cmd.expand_start) begin
      src_r <= cnt_dec;
    end
    if (cmd.expand_step && sts.expand_more) begin
      src_r <= src_dec;
    end
    if (cmd.q_issue) begin
      m_r <= m_w[IW-1:0];
    end
    if (cmd.q_eval) begin
      if (page_lt) begin
        rr_r <= CW'(m_r);
      end else if (page_gt) begin
        l_r <= CW'(m_r) + CW'(1);
      end else begin
        hit_r <= 1'b1;
      end
    end
    if (cmd.res_load) begin
      out_hit_r    <= hit_r;
      out_status_r <= cmd.res_status;
      out_count_r  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.merge_place) begin
        count_r <= count_r - CW'(merged_r) + k_r;
      end else if (cmd.place) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

@@ rtl/mit_ctrl.sv @@
`timescale 1ns / 1ps

module mit_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  mit_pkg::dp_sts_t sts,
  output mit_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_START = 4'd1;
  localparam logic [3:0] S_WALK      = 4'd2;
  localparam logic [3:0] S_DECIDE    = 4'd3;
  localparam logic [3:0] S_COMPACT   = 4'd4;
  localparam logic [3:0] S_EXPAND    = 4'd5;
  localparam logic [3:0] S_PLACE     = 4'd6;
  localparam logic [3:0] S_Q_ISSUE   = 4'd7;
  localparam logic [3:0] S_Q_EVAL    = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]       state_r, state_nxt;
  mit_pkg::status_t status_r, status_nxt;
  logic             ignore_r;

  always_comb begin
    cmd            = '0;
    cmd.res_status = status_r;
    state_nxt      = state_r;
    status_nxt     = status_r;
    in_ready       = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode == mit_pkg::MODE_QUERY) begin
            status_nxt = mit_pkg::ST_QUERY;
            state_nxt  = S_Q_ISSUE;
          end else if (ignore_r) begin
            status_nxt = mit_pkg::ST_IGNORED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_INS_START;
          end
        end
      end
      S_INS_START: begin
        cmd.walk_start = 1'b1;
        state_nxt      = sts.cnt_zero ? S_DECIDE : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_stop) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.found) begin
          cmd.merge_place = 1'b1;
          status_nxt      = mit_pkg::ST_MERGED;
          state_nxt       = sts.tail ? S_COMPACT : S_DONE;
        end else if (sts.cnt_full) begin
          status_nxt = mit_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else if (sts.pos_lt_cnt) begin
          cmd.expand_start = 1'b1;
          state_nxt        = S_EXPAND;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_COMPACT: begin
        cmd.compact_step = 1'b1;
        if (!sts.more_copy) begin
          state_nxt = S_DONE;
        end
      end
      S_EXPAND: begin
        cmd.expand_step = 1'b1;
        if (!sts.expand_more) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        status_nxt = mit_pkg::ST_INSERTED;
        state_nxt  = S_DONE;
      end
      S_Q_ISSUE: begin
        if (sts.q_more) begin
          cmd.q_issue = 1'b1;
          state_nxt   = S_Q_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_Q_EVAL: begin
        cmd.q_eval = 1'b1;
        state_nxt  = sts.q_match ? S_DONE : S_Q_ISSUE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= mit_pkg::ST_MERGED;
      ignore_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (cfg_wr_en) begin
        ignore_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ rtl/merged_interval_table.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    mode, range_start, range_end, query_page
// out_chan  out  valid/ready    hit, status, entry_count
// cfg_*     in   cfg_wr_en      cfg_wr_data (ignore inserts)
//
// A query runs a binary search over the stored ranges; each step waits on the registered memory
// read. An insert walks the stored ranges from the top and moves entries to close or open a gap.
// Reset is synchronous and empties the table at once; no memory clearing pass is needed.
// A result waits in an output register while the next request is taken; one that cannot be
// loaded holds the block.

module merged_interval_table #(
  parameter int MAX_RANGES = 64,
  parameter int PAGE_BITS  = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  mit_req_if.sink      in_chan,
  mit_rsp_if.source    out_chan,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  mit_pkg::dp_cmd_t cmd;
  mit_pkg::dp_sts_t sts;

  // The controller sequences each request: it walks the stored ranges from the highest
  // downward for an insert, then either rewrites the merged entry and closes the gap, or,
  // if the table has room, shifts the upper entries up by one to make room for a new one.
  // A query runs a binary search over the sorted entries.
  mit_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_mode     (in_chan.mode),
    .in_ready    (in_chan.ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  // The datapath owns the range memory, the entry count, the working bounds of the
  // request and the result register.
  mit_dp #(
    .MAX_RANGES (MAX_RANGES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_range_start  (in_chan.range_start),
    .in_range_end    (in_chan.range_end),
    .in_query_page   (in_chan.query_page),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_hit         (out_chan.hit),
    .out_status      (out_chan.status),
    .out_entry_count (out_chan.entry_count)
  );

endmodule

@@ bench/merged_interval_table_test.sv @@
`timescale 1ns / 1ps

module merged_interval_table_test;

  localparam int MAX_RANGES = 64;
  localparam int PAGE_BITS  = 40;
  localparam int COUNT_BITS = 7;

  // Enough points to overrun the table when it is filled on purpose.
  localparam int FILL_POINTS = 70;
  localparam int CHUNKS      = 8;
  localparam int CHUNK_ITEMS = 105;
  localparam int LONG_HOLD   = 300;

  typedef logic [PAGE_BITS-1:0] page_t;

  localparam page_t PAGE_MAX    = '1;
  localparam page_t WINDOW_BASE = page_t'(40'h00_0010_0000);

  // One result as the block should report it.
  typedef struct {
    logic                  hit;
    mit_pkg::status_t      status;
    logic [COUNT_BITS-1:0] entry_count;
  } lookup_result_t;

  // Tracks the range table alongside the block. Every accepted request queues the
  // result that the block owes for it; an insert that is not ignored updates the table.
  class range_table_tracker;
    page_t          lo_tab[MAX_RANGES];
    page_t          hi_tab[MAX_RANGES];
    int             n_ranges;
    bit             ignore_on;
    lookup_result_t expected_results[$];
    int unsigned    mismatches;

    function void set_ignore(bit v);
      ignore_on = v;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Merge a range into the table, or place it as a new sorted entry.
    function mit_pkg::status_t absorb_range(page_t s, page_t e);
      page_t t;
      int    i;
      int    k;
      int    first;
      int    slot;
      int    tail;
      if (s > e) begin
        t = s;
        s = e;
        e = t;
      end
      // Walk down from the top while the range can still reach an entry;
      // widths are extended by one bit so that the touch test cannot wrap.
      first = -1;
      i = n_ranges - 1;
      while (i >= 0 && ({1'b0, s} <= {1'b0, hi_tab[i]} + 41'd1)) begin
        if ({1'b0, e} + 41'd1 >= {1'b0, lo_tab[i]}) begin
          if (lo_tab[i] < s) s = lo_tab[i];
          if (hi_tab[i] > e) e = hi_tab[i];
          if (first < 0) first = i;
        end
        i--;
      end
      slot = i + 1;
      if (first >= 0) begin
        tail = n_ranges - first - 1;
        lo_tab[slot] = s;
        hi_tab[slot] = e;
        for (k = 0; k < tail; k++) begin
          lo_tab[slot + 1 + k] = lo_tab[first + 1 + k];
          hi_tab[slot + 1 + k] = hi_tab[first + 1 + k];
        end
        n_ranges -= first - slot;
        return mit_pkg::ST_MERGED;
      end
      if (n_ranges >= MAX_RANGES) return mit_pkg::ST_FULL;
      for (k = n_ranges; k > slot; k--) begin
        lo_tab[k] = lo_tab[k - 1];
        hi_tab[k] = hi_tab[k - 1];
      end
      lo_tab[slot] = s;
      hi_tab[slot] = e;
      n_ranges++;
      return mit_pkg::ST_INSERTED;
    endfunction

    function void note_request(logic mode, page_t s, page_t e, page_t p);
      lookup_result_t r;
      int             k;
      r.hit = 1'b0;
      if (mode == mit_pkg::MODE_QUERY) begin
        for (k = 0; k < n_ranges; k++)
          if (p >= lo_tab[k] && p <= hi_tab[k]) r.hit = 1'b1;
        r.status = mit_pkg::ST_QUERY;
      end else if (ignore_on) begin
        r.status = mit_pkg::ST_IGNORED;
      end else begin
        r.status = absorb_range(s, e);
      end
      r.entry_count = COUNT_BITS'(n_ranges);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic hit, mit_pkg::status_t status,
                               logic [COUNT_BITS-1:0] cnt);
      lookup_result_t r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: hit %b status %0d count %0d", hit, status, cnt);
        return;
      end
      r = expected_results.pop_front();
      if (hit !== r.hit || status !== r.status || cnt !== r.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected hit %b status %0d count %0d, got hit %b status %0d count %0d",
                   r.hit, r.status, r.entry_count, hit, status, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  mit_req_if #(.PAGE_BITS(PAGE_BITS))   req_chan ();
  mit_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_chan ();

  merged_interval_table #(
    .MAX_RANGES(MAX_RANGES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (req_chan),
    .out_chan   (rsp_chan),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  range_table_tracker table_track = new();

  // Knobs that shape the traffic of each phase. The stimulus sets them; the
  // sender and the receiver read them.
  bit sender_gaps_on = 1'b1;
  bit rx_stalls_on   = 1'b1;
  bit rx_hold_req    = 1'b0;

  always #6 clk = ~clk;

  // Every input starts at a known value before the first clock edge.
  initial begin
    req_chan.valid       = 1'b0;
    req_chan.mode        = mit_pkg::MODE_INSERT;
    req_chan.range_start = '0;
    req_chan.range_end   = '0;
    req_chan.query_page  = '0;
    rsp_chan.ready       = 1'b0;
  end

  // The run may not hang: the slowest correct run is far below this bound.
  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver. Every result is checked at the edge that accepts it. After each
  // result a random stall is drawn, unless the phase has stalls off. A long
  // hold, once asked for, keeps ready low long enough that the block backs up
  // and stops taking requests.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rsp_chan.valid && rsp_chan.ready) begin
        table_track.check_result(rsp_chan.hit, rsp_chan.status, rsp_chan.entry_count);
        stall_left = rx_stalls_on ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold_req) begin
        hold_left   = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_chan.ready <= 1'b0;
      end else begin
        rsp_chan.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic page_t rand_page();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  // Offers one request and returns at the edge that accepts it. The valid line
  // is only lowered when a gap is drawn, so a back-to-back request keeps it high.
  task automatic send_request(logic mode, page_t s, page_t e, page_t p);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.mode        <= mode;
    req_chan.range_start <= s;
    req_chan.range_end   <= e;
    req_chan.query_page  <= p;
    req_chan.valid       <= 1'b1;
    do @(posedge clk); while (!req_chan.ready);
    table_track.note_request(mode, s, e, p);
  endtask

  // The unused fields of each kind of request carry random values.
  task automatic send_insert(page_t s, page_t e);
    send_request(mit_pkg::MODE_INSERT, s, e, rand_page());
  endtask

  task automatic send_query(page_t p);
    send_request(mit_pkg::MODE_QUERY, rand_page(), rand_page(), p);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic settle();
    req_chan.valid <= 1'b0;
    while (table_track.outstanding() != 0) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_ignore(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    table_track.set_ignore(v);
  endtask

  initial begin : stimulus
    int    c;
    int    n;
    int    k;
    int    j;
    int    r;
    int    len;
    int    fill_order[FILL_POINTS];
    page_t base;
    page_t a;
    page_t b;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: an empty table, the lowest and highest pages, ranges
    // that touch without overlapping, a reversed range, and a merge that
    // swallows several entries at once.
    send_query('0);
    send_query(PAGE_MAX);
    send_insert('0, '0);
    send_insert(PAGE_MAX, PAGE_MAX);
    send_query(PAGE_MAX);
    send_query('0);
    send_insert(page_t'(10), page_t'(20));
    send_insert(page_t'(30), page_t'(22));
    send_insert(page_t'(21), page_t'(21));
    send_insert(page_t'(1), page_t'(9));
    send_query(page_t'(30));
    send_query(page_t'(31));
    send_query(PAGE_MAX - 1);
    send_insert(page_t'(40), page_t'(50));
    send_insert(page_t'(45), page_t'(60));
    send_insert(page_t'(70), page_t'(80));
    send_insert(page_t'(35), page_t'(90));
    send_insert(PAGE_MAX - 5, PAGE_MAX - 1);

    // Inserts are skipped while the ignore bit is set; queries still answer.
    settle();
    write_ignore(1'b1);
    send_insert(page_t'(100), page_t'(200));
    send_query(page_t'(15));
    send_query(page_t'(150));
    settle();
    write_ignore(1'b0);
    send_insert(page_t'(100), page_t'(200));

    // Fill the table with isolated single pages in shuffled order until it is
    // full and further new ranges are dropped.
    for (k = 0; k < FILL_POINTS; k++) fill_order[k] = k;
    for (k = FILL_POINTS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      n = fill_order[k];
      fill_order[k] = fill_order[j];
      fill_order[j] = n;
    end
    for (k = 0; k < FILL_POINTS; k++) begin
      a = WINDOW_BASE + page_t'(4 * fill_order[k]);
      send_insert(a, a);
    end
    send_query(WINDOW_BASE + page_t'(8));
    send_query(WINDOW_BASE + page_t'(9));
    // A full table still takes a range that merges with a stored one.
    send_insert(WINDOW_BASE + page_t'(1), WINDOW_BASE + page_t'(1));

    // Random phases. Most inserts are short ranges inside a small window so that
    // they merge, bridge gaps and hit the full table; some land anywhere in the
    // page space, and a few sit at its ends.
    for (c = 0; c < CHUNKS; c++) begin
      settle();
      write_ignore(c == 2 || c == 5);
      sender_gaps_on = (c % 4 != 1);
      rx_stalls_on   = (c % 4 != 2);
      // One phase starts with a long hold at the receiver while requests keep coming.
      if (c == 4) rx_hold_req = 1'b1;
      base = WINDOW_BASE + page_t'((c % 3) * 4096);
      for (n = 0; n < CHUNK_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        len = $urandom_range(0, 3);
        if (r < 40) begin
          if ($urandom_range(0, 9) < 7)
            send_query(base - page_t'(8) + page_t'($urandom_range(0, 300)));
          else
            send_query(rand_page());
        end else if (r < 95) begin
          if (r < 85) a = base + page_t'($urandom_range(0, 287));
          else a = rand_page();
          b = (a > PAGE_MAX - page_t'(len)) ? PAGE_MAX : a + page_t'(len);
          if ($urandom_range(0, 4) == 0) send_insert(b, a);
          else send_insert(a, b);
        end else if (r < 97) begin
          send_insert('0, page_t'(len));
        end else begin
          send_insert(PAGE_MAX - page_t'(len), PAGE_MAX);
        end
      end
    end

    // One range over the whole page space collapses the table to a single entry.
    settle();
    write_ignore(1'b0);
    send_insert('0, PAGE_MAX);
    send_query(rand_page());
    settle();

    // Leave room for any stray result before the verdict.
    repeat (2 * MAX_RANGES + 20) @(posedge clk);
    if (table_track.mismatches == 0 && table_track.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
